@@ rtl/heartbeat_supervisor_escalation_top_defines.svh @@
// ----------------------------------------------------------------------------
// heartbeat supervisor escalation - assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_SUPERVISOR_ESCALATION_TOP_DEFINES_SVH
`define HEARTBEAT_SUPERVISOR_ESCALATION_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HSE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define HSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hse_pkg.sv @@
// ----------------------------------------------------------------------------
// hse_pkg
// types, widths, register codes and reset values of the heartbeat supervisor
// ----------------------------------------------------------------------------
package hse_pkg;

    // field widths
    localparam int TimeW    = 32;
    localparam int StaleW   = 16;
    localparam int MissW    = 8;
    localparam int StrikeW  = 8;
    localparam int WindowW  = 16;
    localparam int BurstW   = 5;

    // stream and config port widths
    localparam int InTdataW  = 104;
    localparam int OutTdataW = 8;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    // config register codes
    typedef enum logic [CfgIdxW-1:0] {
        REG_STALE_LIMIT    = 3'd0,
        REG_MISSING_LIMIT  = 3'd1,
        REG_STRIKES_NEEDED = 3'd2,
        REG_BURST_WINDOW   = 3'd3,
        REG_BURST_COUNT    = 3'd4
    } t_cfg_reg;

    // reset values
    localparam logic [StaleW-1:0]  StaleLimitRst    = 16'd180;
    localparam logic [MissW-1:0]   MissingLimitRst  = 8'd30;
    localparam logic [StrikeW-1:0] StrikesNeededRst = 8'd3;
    localparam logic [WindowW-1:0] BurstWindowRst   = 16'd7200;
    localparam logic [BurstW-1:0]  BurstCountRst    = 5'd12;

    // saturation level of miss and strike counters
    localparam logic [MissW-1:0]   MissMax   = 8'hFF;
    localparam logic [StrikeW-1:0] StrikeMax = 8'hFF;

    typedef struct packed {
        logic [StaleW-1:0]  stale_limit;
        logic [MissW-1:0]   missing_limit;
        logic [StrikeW-1:0] strikes_needed;
        logic [WindowW-1:0] burst_window;
        logic [BurstW-1:0]  burst_count;
    } t_cfg;

    // what one lane found for the item in flight
    typedef struct packed {
        logic stale;
        logic push;
    } t_lane_res;

endpackage

@@ rtl/hse_lane.sv @@
// ----------------------------------------------------------------------------
// hse_lane
// per-module heartbeat age check with saturating strike counter
// ----------------------------------------------------------------------------
module hse_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic                            i_present,
    input  logic [hse_pkg::TimeW-1:0]       i_now,
    input  logic [hse_pkg::TimeW-1:0]       i_beat,
    input  logic [hse_pkg::StaleW-1:0]      i_stale_limit,
    input  logic [hse_pkg::StrikeW-1:0]     i_strikes_needed,
    output hse_pkg::t_lane_res              o_res
);

    logic [hse_pkg::TimeW-1:0]   age_diff;
    logic [hse_pkg::TimeW-1:0]   age_mag;
    logic                        is_stale;
    logic [hse_pkg::StrikeW-1:0] strike_inc;
    logic [hse_pkg::StrikeW-1:0] r_strike;
    logic [hse_pkg::StrikeW-1:0] n_strike;
    hse_pkg::t_lane_res          r_res;
    hse_pkg::t_lane_res          n_res;

    // magnitude of the signed age
    always_comb begin
        age_diff = i_now - i_beat;
        age_mag  = age_diff[hse_pkg::TimeW-1] ? (~age_diff + 1'b1) : age_diff;
        is_stale = age_mag > {{(hse_pkg::TimeW-hse_pkg::StaleW){1'b0}}, i_stale_limit};
    end

    // strike update and restart decision
    always_comb begin
        strike_inc = (r_strike == hse_pkg::StrikeMax) ? r_strike : r_strike + 1'b1;
        n_strike   = r_strike;
        n_res      = '0;
        if (i_present) begin
            if (is_stale) begin
                n_strike   = strike_inc;
                n_res.stale = 1'b1;
                n_res.push  = strike_inc >= i_strikes_needed;
            end else begin
                n_strike = '0;
            end
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strike <= '0;
            r_res    <= '0;
        end else if (i_load) begin
            r_strike <= n_strike;
            r_res    <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

@@ rtl/hse_merge.sv @@
// ----------------------------------------------------------------------------
// hse_merge
// restart history shift and burst window test over the lane pushes
// ----------------------------------------------------------------------------
module hse_merge #(
    parameter int HISTORY_DEPTH = 20,
    parameter int MODULES       = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [hse_pkg::TimeW-1:0]       i_now,
    input  logic                            i_clear,
    input  logic [MODULES-1:0]              i_push,
    input  logic [hse_pkg::WindowW-1:0]     i_burst_window,
    input  logic [hse_pkg::BurstW-1:0]      i_burst_count,
    output logic                            o_burst
);

    localparam int IdxW = $clog2(HISTORY_DEPTH);
    localparam int KW   = $clog2(MODULES + 1);

    logic [hse_pkg::TimeW-1:0] r_hist [HISTORY_DEPTH];
    logic [hse_pkg::TimeW-1:0] n_hist [HISTORY_DEPTH];
    logic [hse_pkg::TimeW-1:0] base   [HISTORY_DEPTH];
    logic [KW-1:0]             push_cnt;
    logic [MODULES-1:0]        hit;
    int                        n_back;

    // count of pushes this item, all of the same time
    always_comb begin
        push_cnt = '0;
        for (int m = 0; m < MODULES; m++) begin
            push_cnt = push_cnt + KW'(i_push[m]);
        end
    end

    // clamp the look-back distance to the history
    always_comb begin
        n_back = int'(i_burst_count);
        if (n_back < 1) begin
            n_back = 1;
        end
        if (n_back > HISTORY_DEPTH) begin
            n_back = HISTORY_DEPTH;
        end
    end

    // history after an optional clear
    always_comb begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            base[i] = i_clear ? '0 : r_hist[i];
        end
    end

    // burst test after each push, newest at the top index
    always_comb begin
        logic [hse_pkg::TimeW-1:0] past;
        logic [hse_pkg::TimeW-1:0] diff;
        for (int j = 1; j <= MODULES; j++) begin
            if (n_back <= j) begin
                past = i_now;
            end else begin
                past = base[IdxW'(HISTORY_DEPTH - n_back + j)];
            end
            diff = i_now - past;
            hit[j-1] = (j <= int'(push_cnt)) &&
                       (diff[hse_pkg::TimeW-1] ||
                        (diff < {{(hse_pkg::TimeW-hse_pkg::WindowW){1'b0}}, i_burst_window}));
        end
    end

    assign o_burst = |hit;

    // shift in the pushed times
    always_comb begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (i + int'(push_cnt) >= HISTORY_DEPTH) begin
                n_hist[i] = i_now;
            end else begin
                n_hist[i] = base[IdxW'(i + int'(push_cnt))];
            end
        end
    end

    // history register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_load) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= n_hist[i];
            end
        end
    end

endmodule

@@ rtl/heartbeat_supervisor_escalation_top.sv @@
// ----------------------------------------------------------------------------
// heartbeat_supervisor_escalation_top
// heartbeat supervisor with restart history and reboot escalation
// ----------------------------------------------------------------------------
// One check transfer is taken every clock cycle while the output side is not
// stalled, and each gives one result transfer through the first-stage and output
// registers. The first stage runs one age/strike lane per supervised module plus
// the miss counter, the second stage merges the lane pushes into the restart
// history and runs the burst window test; the output register lets a new check
// enter while a result still waits. Config writes are taken every cycle.
module heartbeat_supervisor_escalation_top #(
    parameter int HISTORY_DEPTH = 20,
    parameter int MODULES       = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hse_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [hse_pkg::CfgDataW-1:0]     i_cfg_data,
    // check input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_seconds[31:0], beat_time_first[63:32], beat_time_second[95:64],
    // clear_history[96], zero pad[103:97]
    input  logic [hse_pkg::InTdataW-1:0]     s_axis_tdata,
    // beats_present
    input  logic                             s_axis_tuser,
    // result output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // reboot_request[0], restart_request[1], stale_mask[3:2], zero pad[7:4]
    output logic [hse_pkg::OutTdataW-1:0]    m_axis_tdata
);

    localparam int TW = hse_pkg::TimeW;

    hse_pkg::t_cfg             r_cfg;
    logic [hse_pkg::MissW-1:0] r_miss;
    logic [hse_pkg::MissW-1:0] miss_inc;
    logic                      r_s1_valid;
    logic                      r_s1_miss_reboot;
    logic                      r_s1_clear;
    logic [TW-1:0]             r_s1_now;
    logic                      r_m_valid;
    logic                      r_reboot;
    logic                      r_restart;
    logic [1:0]                r_mask;
    logic                      out_free;
    logic                      load_out;
    logic                      accept;
    logic                      burst;
    logic [MODULES-1:0]        push_vec;
    logic [1:0]                mask;
    hse_pkg::t_lane_res        lane_res [MODULES];
    logic [TW-1:0]             in_now;
    logic [TW-1:0]             in_beat [2];
    logic                      in_clear;

    // input field unpacking
    assign in_now     = s_axis_tdata[TW-1:0];
    assign in_beat[0] = s_axis_tdata[2*TW-1:TW];
    assign in_beat[1] = s_axis_tdata[3*TW-1:2*TW];
    assign in_clear   = s_axis_tdata[3*TW];

    // handshake and stage advance
    assign out_free      = !r_m_valid || m_axis_tready;
    assign load_out      = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stale_limit    <= hse_pkg::StaleLimitRst;
            r_cfg.missing_limit  <= hse_pkg::MissingLimitRst;
            r_cfg.strikes_needed <= hse_pkg::StrikesNeededRst;
            r_cfg.burst_window   <= hse_pkg::BurstWindowRst;
            r_cfg.burst_count    <= hse_pkg::BurstCountRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hse_pkg::REG_STALE_LIMIT: begin
                    r_cfg.stale_limit <= i_cfg_data[hse_pkg::StaleW-1:0];
                end
                hse_pkg::REG_MISSING_LIMIT: begin
                    r_cfg.missing_limit <= i_cfg_data[hse_pkg::MissW-1:0];
                end
                hse_pkg::REG_STRIKES_NEEDED: begin
                    r_cfg.strikes_needed <= i_cfg_data[hse_pkg::StrikeW-1:0];
                end
                hse_pkg::REG_BURST_WINDOW: begin
                    r_cfg.burst_window <= i_cfg_data[hse_pkg::WindowW-1:0];
                end
                hse_pkg::REG_BURST_COUNT: begin
                    r_cfg.burst_count <= i_cfg_data[hse_pkg::BurstW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // one lane per supervised module, beats alternate between the two fields
    for (genvar g = 0; g < MODULES; g++) begin : g_lane
        hse_lane u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_load           (accept),
            .i_present        (s_axis_tuser),
            .i_now            (in_now),
            .i_beat           (in_beat[g % 2]),
            .i_stale_limit    (r_cfg.stale_limit),
            .i_strikes_needed (r_cfg.strikes_needed),
            .o_res            (lane_res[g])
        );
        assign push_vec[g] = lane_res[g].push;
    end

    // stale mask covers the first two modules
    assign mask[0] = lane_res[0].stale;
    if (MODULES > 1) begin : g_mask_two
        assign mask[1] = lane_res[MODULES > 1 ? 1 : 0].stale;
    end else begin : g_mask_one
        assign mask[1] = 1'b0;
    end

    // miss counter and first stage
    assign miss_inc = (r_miss == hse_pkg::MissMax) ? r_miss : r_miss + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss           <= '0;
            r_s1_valid       <= 1'b0;
            r_s1_miss_reboot <= 1'b0;
            r_s1_clear       <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1_clear <= in_clear;
                if (s_axis_tuser) begin
                    r_miss           <= '0;
                    r_s1_miss_reboot <= 1'b0;
                end else begin
                    r_miss           <= miss_inc;
                    r_s1_miss_reboot <= miss_inc > r_cfg.missing_limit;
                end
            end else if (load_out) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_now <= in_now;
        end
    end

    // history merge and burst test
    hse_merge #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MODULES       (MODULES)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load_out),
        .i_now          (r_s1_now),
        .i_clear        (r_s1_clear),
        .i_push         (push_vec),
        .i_burst_window (r_cfg.burst_window),
        .i_burst_count  (r_cfg.burst_count),
        .o_burst        (burst)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_reboot  <= r_s1_miss_reboot || burst;
            r_restart <= |push_vec;
            r_mask    <= mask;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0000, r_mask, r_restart, r_reboot};

endmodule

@@ rtl/hse_checker.sv @@
// ----------------------------------------------------------------------------
// hse_checker
// port-level assertions for the heartbeat supervisor, bound to the top level
// ----------------------------------------------------------------------------
`include "heartbeat_supervisor_escalation_top_defines.svh"

module hse_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [hse_pkg::OutTdataW-1:0]    m_axis_tdata
);

    // a stalled result transfer keeps its payload
    `HSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // input only backs up when a result is waiting at the output
    `HSE_ASSERT_SAME(a_in_stall, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

    // a restart always comes with a stale module
    `HSE_ASSERT_SAME(a_restart_stale, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[3:2] != 2'b00, "restart without stale module")

    // input stall never lasts past a free output
    `HSE_ASSERT_NEXT(a_in_release, i_clk, i_rst_n, s_axis_tvalid && !s_axis_tready && m_axis_tready, s_axis_tready, "input stall held after output transfer")

endmodule

bind heartbeat_supervisor_escalation_top hse_checker u_hse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ test/tb_heartbeat_supervisor_escalation_top.sv @@
// ----------------------------------------------------------------------------
// tb_heartbeat_supervisor_escalation_top
// self-checking bench for the heartbeat supervisor with restart escalation:
// directed checks of ages, strikes, miss runs and burst history, then phases
// of random heartbeat traffic; a local predictor scores every result transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_heartbeat_supervisor_escalation_top;

    localparam int HIST      = 20;
    localparam int LANES     = 2;
    localparam int CYCLE_CAP = 800000;

    // register indexes past the end of the register list
    localparam logic [hse_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [hse_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [hse_pkg::TimeW-1:0] now_s;
        logic                      present;
        logic [hse_pkg::TimeW-1:0] beat0;
        logic [hse_pkg::TimeW-1:0] beat1;
        logic                      clear;
    } t_check;

    typedef struct packed {
        logic       reboot;
        logic       restart;
        logic [1:0] stale;
    } t_verdict;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [hse_pkg::CfgIdxW-1:0]   i_cfg_index;
    logic [hse_pkg::CfgDataW-1:0]  i_cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [hse_pkg::InTdataW-1:0]  s_axis_tdata;
    logic                          s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [hse_pkg::OutTdataW-1:0] m_axis_tdata;

    // predictor copy of configuration and state
    hse_pkg::t_cfg cfg;
    logic [7:0]    miss_cnt;
    logic [7:0]    strikes [LANES];
    logic [31:0]   restart_log [HIST];

    t_verdict      verdict_q [$];
    int unsigned   mismatches;
    int unsigned   cycle_cnt;
    int unsigned   ready_hold;
    logic          src_gaps;
    logic          sink_stalls;

    heartbeat_supervisor_escalation_top #(
        .HISTORY_DEPTH(HIST),
        .MODULES      (LANES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_check mk(logic [31:0] now_s, logic present, logic [31:0] b0,
                                  logic [31:0] b1, logic clear);
        t_check c;
        c.now_s   = now_s;
        c.present = present;
        c.beat0   = b0;
        c.beat1   = b1;
        c.clear   = clear;
        return c;
    endfunction

    // predicts one check and advances the local state
    function automatic t_verdict supervise(t_check c);
        t_verdict    v;
        logic [31:0] beat;
        logic [31:0] age;
        logic [31:0] span;
        int unsigned back;
        v = '0;
        if (c.clear)
            for (int k = 0; k < HIST; k++) restart_log[k] = '0;
        if (!c.present) begin
            if (miss_cnt != hse_pkg::MissMax) miss_cnt++;
            if (miss_cnt > cfg.missing_limit) v.reboot = 1'b1;
        end else begin
            miss_cnt = '0;
            for (int m = 0; m < LANES; m++) begin
                beat = (m == 0) ? c.beat0 : c.beat1;
                age  = c.now_s - beat;
                if (age[31]) age = 32'd0 - age;
                if (age > {16'd0, cfg.stale_limit}) begin
                    v.stale[m] = 1'b1;
                    if (strikes[m] != hse_pkg::StrikeMax) strikes[m]++;
                    if (strikes[m] >= cfg.strikes_needed) begin
                        v.restart = 1'b1;
                        // log the restart, then look burst_count entries back
                        for (int k = 0; k < HIST - 1; k++) restart_log[k] = restart_log[k + 1];
                        restart_log[HIST - 1] = c.now_s;
                        back = 32'(cfg.burst_count);
                        if (back < 1) back = 1;
                        if (back > HIST) back = HIST;
                        span = c.now_s - restart_log[HIST - back];
                        if (span[31] || span < {16'd0, cfg.burst_window}) v.reboot = 1'b1;
                    end
                end else begin
                    strikes[m] = '0;
                end
            end
        end
        return v;
    endfunction

    // one check transfer; leaves tvalid high so back-to-back items need no re-raise
    task automatic send_check(input t_check c);
        int unsigned g;
        g = src_gaps ? pick_gap() : 0;
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tdata  <= {7'd0, c.clear, c.beat1, c.beat0, c.now_s};
        s_axis_tuser  <= c.present;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        verdict_q.push_back(supervise(c));
    endtask

    // stop sending and let every pending result come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register transfer; caller lowers valid when done
    task automatic write_reg(input logic [hse_pkg::CfgIdxW-1:0] idx,
                             input logic [hse_pkg::CfgDataW-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            hse_pkg::REG_STALE_LIMIT:    cfg.stale_limit    = data;
            hse_pkg::REG_MISSING_LIMIT:  cfg.missing_limit  = data[7:0];
            hse_pkg::REG_STRIKES_NEEDED: cfg.strikes_needed = data[7:0];
            hse_pkg::REG_BURST_WINDOW:   cfg.burst_window   = data;
            hse_pkg::REG_BURST_COUNT:    cfg.burst_count    = data[4:0];
            default: ;
        endcase
    endtask

    // junk in the unused upper data bits must be dropped by the narrow registers
    task automatic configure(input logic [15:0] stale_lim, input logic [7:0] miss_lim,
                             input logic [7:0] needed, input logic [15:0] window,
                             input logic [4:0] burst);
        drain();
        write_reg(hse_pkg::REG_STALE_LIMIT, stale_lim);
        write_reg(hse_pkg::REG_MISSING_LIMIT, {8'($urandom), miss_lim});
        write_reg(hse_pkg::REG_STRIKES_NEEDED, {8'($urandom), needed});
        write_reg(hse_pkg::REG_BURST_WINDOW, window);
        write_reg(hse_pkg::REG_BURST_COUNT, {11'($urandom), burst});
        i_cfg_valid <= 1'b0;
    endtask

    // reset settings: fresh, stale, strikes, both lanes, signed ages, misses
    task automatic test_reset_settings();
        send_check(mk(32'd1000, 1'b1, 32'd990, 32'd1000, 1'b0));
        repeat (3) send_check(mk(32'd1000, 1'b1, 32'd0, 32'd995, 1'b0));
        send_check(mk(32'd1100, 1'b1, 32'd0, 32'd1100, 1'b1));
        repeat (3) send_check(mk(32'd5000, 1'b1, 32'd0, 32'hFFFF_FFFF, 1'b0));
        send_check(mk(32'd0, 1'b1, 32'hFFFF_FFFF, 32'd0, 1'b0));
        send_check(mk(32'hFFFF_FFFF, 1'b1, 32'd0, 32'hFFFF_FF00, 1'b0));
        send_check(mk(32'h8000_0000, 1'b1, 32'd0, 32'h8000_00B4, 1'b0));
        send_check(mk(32'h8000_0000, 1'b1, 32'h8000_00B5, 32'hFFFF_FFFF, 1'b0));
        send_check(mk(32'd2000, 1'b1, 32'd3000, 32'd2180, 1'b0));
        repeat (2) send_check(mk(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_check(mk(32'd2100, 1'b1, 32'd2100, 32'd2000, 1'b0));
    endtask

    // miss counter: zero limit, saturation with the never-reboot limit,
    // then a limit just below the saturated count
    task automatic test_miss_escalation();
        configure(16'd180, 8'd0, 8'd3, 16'd7200, 5'd12);
        send_check(mk(32'd10, 1'b0, 32'd0, 32'd0, 1'b0));
        send_check(mk(32'd20, 1'b1, 32'd20, 32'd20, 1'b0));
        configure(16'd180, 8'd255, 8'd3, 16'd7200, 5'd12);
        repeat (262) send_check(mk($urandom, 1'b0, $urandom, $urandom, 1'($urandom)));
        configure(16'd180, 8'd254, 8'd3, 16'd7200, 5'd12);
        repeat (6) send_check(mk($urandom, 1'b0, $urandom, $urandom, 1'b0));
        send_check(mk(32'd30, 1'b1, 32'd30, 32'd30, 1'b0));
    endtask

    // strike counters held at 255 by saturation keep restarting, and a zero threshold restarts at once
    task automatic test_strike_limits();
        logic [31:0] t;
        configure(16'd0, 8'd30, 8'd255, 16'd100, 5'd20);
        t = 32'h7FFF_FF00;
        repeat (262) begin
            t = t + 32'd7;
            send_check(mk(t, 1'b1, t - 32'd1, t + 32'd3, 1'b0));
        end
        configure(16'd50, 8'd30, 8'd0, 16'd65535, 5'd3);
        send_check(mk(32'd1000, 1'b1, 32'd900, 32'd1000, 1'b1));
        send_check(mk(32'd1010, 1'b1, 32'd1010, 32'd900, 1'b0));
        send_check(mk(32'd1020, 1'b1, 32'd900, 32'd900, 1'b0));
    endtask

    // burst depth below one, at the ends and above the history, window extremes,
    // and a clock that steps back
    task automatic test_burst_depth();
        logic [4:0]  depth [5] = '{5'd0, 5'd1, 5'd20, 5'd25, 5'd31};
        logic [15:0] window;
        logic [31:0] t;
        for (int d = 0; d < 5; d++) begin
            window = (d == 1) ? 16'd0 : ((d == 2) ? 16'd65535 : 16'd1500);
            configure(16'd10, 8'd30, 8'd1, window, depth[d]);
            t = 32'd100_000;
            send_check(mk(t, 1'b1, t, t, 1'b1));
            for (int k = 0; k < 22; k++) begin
                t = t + 32'd97;
                send_check(mk(t, 1'b1, t - 32'd500, (k % 3 == 0) ? t - 32'd20 : t, 1'b0));
            end
            t = t - 32'd5000;
            send_check(mk(t, 1'b1, t - 32'd500, t, 1'b0));
        end
    endtask

    // writes past the register list leave every setting as it was
    task automatic test_spare_index();
        configure(16'd40, 8'd2, 8'd2, 16'd3000, 5'd4);
        @(posedge i_clk);
        for (int k = REG_SPARE_LO; k <= REG_SPARE_HI; k++) write_reg(k[2:0], 16'($urandom));
        i_cfg_valid <= 1'b0;
        repeat (4) send_check(mk(32'd9000, 1'b1, 32'd8000, 32'd9000, 1'b0));
        repeat (4) send_check(mk(32'd9100, 1'b0, 32'd0, 32'd0, 1'b0));
    endtask

    // random heartbeat traffic: advancing clock, modules that die and recover,
    // miss runs, history clears, beats from the future and pure noise
    task automatic run_traffic(input int unsigned count);
        t_check      c;
        logic [31:0] t;
        logic [31:0] last_beat [LANES];
        logic        alive [LANES];
        int unsigned miss_run;
        int unsigned r;
        t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 2047) : $urandom;
        miss_run = 0;
        for (int m = 0; m < LANES; m++) begin
            alive[m]     = 1'b1;
            last_beat[m] = t;
        end
        repeat (count) begin
            t = t + $urandom_range(1, 90);
            for (int m = 0; m < LANES; m++) begin
                if ($urandom_range(0, 99) < 8) alive[m] = !alive[m];
                if (alive[m]) last_beat[m] = t - $urandom_range(0, 40);
            end
            r = $urandom_range(0, 99);
            if (miss_run == 0 && r < 3) miss_run = $urandom_range(1, 40);
            c = mk(t, 1'b1, last_beat[0], last_beat[1], $urandom_range(0, 99) < 2);
            if (miss_run != 0) begin
                miss_run--;
                c.present = 1'b0;
            end else if (r >= 94) begin
                c = mk($urandom, 1'($urandom), $urandom, $urandom, 1'($urandom));
            end else if (r >= 91) begin
                c.beat1 = t + $urandom_range(0, 1000);
            end
            send_check(c);
        end
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: configure(16'd180, 8'd30, 8'd3, 16'd7200, 5'd12);
                1: configure(16'd0, 8'd0, 8'd1, 16'd65535, 5'd20);
                2: configure(16'd65535, 8'd255, 8'd255, 16'd0, 5'd1);
                default: configure(16'($urandom_range(0, 400)), 8'($urandom_range(0, 10)),
                                   8'($urandom_range(1, 6)), 16'($urandom),
                                   5'($urandom_range(1, 20)));
            endcase
            src_gaps    = (p % 3 != 2);
            sink_stalls = (p % 3 != 1);
            run_traffic(70);
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // result side backpressure
    always @(posedge i_clk) begin
        if (!sink_stalls) begin
            m_axis_tready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) < 65);
            ready_hold    <= pick_gap();
        end
    end

    // score each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $error("result transfer with nothing pending: tdata %02h", m_axis_tdata);
                mismatches++;
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want.reboot) begin
                    $error("reboot_request expected %0d actual %0d", want.reboot,
                           m_axis_tdata[0]);
                    mismatches++;
                end
                if (m_axis_tdata[1] !== want.restart) begin
                    $error("restart_request expected %0d actual %0d", want.restart,
                           m_axis_tdata[1]);
                    mismatches++;
                end
                if (m_axis_tdata[3:2] !== want.stale) begin
                    $error("stale_mask expected %0d actual %0d", want.stale,
                           m_axis_tdata[3:2]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        mismatches    = 0;
        cycle_cnt     = 0;
        ready_hold    = 0;
        src_gaps      = 1'b1;
        sink_stalls   = 1'b1;
        cfg           = '{hse_pkg::StaleLimitRst, hse_pkg::MissingLimitRst,
                          hse_pkg::StrikesNeededRst, hse_pkg::BurstWindowRst,
                          hse_pkg::BurstCountRst};
        miss_cnt      = '0;
        for (int m = 0; m < LANES; m++) strikes[m] = '0;
        for (int k = 0; k < HIST; k++) restart_log[k] = '0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_settings();
        test_miss_escalation();
        test_strike_limits();
        test_burst_depth();
        test_spare_index();
        test_random_phases();

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
